// File: rtl/lms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_pkg: shared constants and types of the little-endian memory stack unit
// Memory geometry, action codes and the request structs that pass between
// the top level and the byte bank array.
// ----------------------------------------------------------------------------
package lms_pkg;

  // Memory size in bytes; a power of two, at least 16
  localparam int MEM_BYTES  = 65536;
  localparam int ADDR_W     = $clog2(MEM_BYTES);
  localparam int LANES      = 4;
  localparam int LANE_W     = 2;
  localparam int BANK_DEPTH = MEM_BYTES / LANES;
  localparam int BANK_AW    = ADDR_W - LANE_W;

  localparam logic [2:0] ACT_RD8  = 3'd0;
  localparam logic [2:0] ACT_RD32 = 3'd1;
  localparam logic [2:0] ACT_WR8  = 3'd2;
  localparam logic [2:0] ACT_WR32 = 3'd3;
  localparam logic [2:0] ACT_PUSH = 3'd4;
  localparam logic [2:0] ACT_POP  = 3'd5;
  localparam logic [2:0] ACT_CALL = 3'd6;
  localparam logic [2:0] ACT_RET  = 3'd7;

  localparam logic [31:0] SP_STEP = 32'd4;
  localparam logic [31:0] CALL_LEN = 32'd5;

  // One memory access issued by an accepted item
  typedef struct packed {
    logic              en;
    logic              we;
    logic              word;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
  } lms_req_t;

  // Clearing pass control
  typedef struct packed {
    logic               active;
    logic [BANK_AW-1:0] row;
  } lms_clr_t;

endpackage

// File: rtl/lms_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_req_if / lms_rsp_if: valid-ready channels of the memory stack unit
// Request carries one action with the current pointers; response carries
// the loaded data and the updated pointers.
// ----------------------------------------------------------------------------
interface lms_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [31:0]        addr;
  logic [31:0]        data;
  logic signed [31:0] rel;
  logic [31:0]        stack_ptr;
  logic [31:0]        instr_ptr;

  modport source (output valid, action, addr, data, rel, stack_ptr, instr_ptr,
                  input ready);
  modport sink (input valid, action, addr, data, rel, stack_ptr, instr_ptr,
                output ready);
endinterface

interface lms_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [31:0] new_stack_ptr;
  logic [31:0] new_instr_ptr;

  modport source (output valid, read_data, new_stack_ptr, new_instr_ptr,
                  input ready);
  modport sink (input valid, read_data, new_stack_ptr, new_instr_ptr,
                output ready);
endinterface

// File: rtl/lms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_ram: generic single-port RAM
// One access per cycle; read data is registered and holds until next read.
// ----------------------------------------------------------------------------
module lms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/lms_banks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_banks: four byte-wide banks serving unaligned little-endian words
// Steers each byte of a word to its bank and row, clears rows on request,
// and rotates the registered bank outputs back into byte order.
// ----------------------------------------------------------------------------
module lms_banks import lms_pkg::*; (
  input  logic        clk,
  input  lms_req_t    req,
  input  lms_clr_t    clr,
  output logic [31:0] rword
);

  logic [BANK_AW-1:0] row_base;
  logic [LANE_W-1:0]  off;
  logic [LANE_W-1:0]  off_q;
  logic [7:0]         q [LANES];

  assign row_base = req.addr[ADDR_W-1:LANE_W];
  assign off      = req.addr[LANE_W-1:0];

  // Hold the lane offset of the last read for the rotation
  always_ff @(posedge clk) begin
    if (req.en && !req.we) begin
      off_q <= off;
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [LANE_W-1:0]  lane;
    logic [LANE_W-1:0]  idx;
    logic [31:0]        wsh;
    logic [BANK_AW-1:0] row;
    logic               lane_we;
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [7:0]         wbyte;
    logic [BANK_AW-1:0] rd_row;

    assign lane = LANE_W'(j);
    // Lanes below the offset hold bytes of the next row, wrapping at the top
    assign row  = row_base + BANK_AW'(lane < off);
    assign idx  = lane - off;
    assign wsh  = req.wdata >> {idx, 3'b000};
    assign rd_row = row;

    always_comb begin
      if (clr.active) begin
        en      = 1'b1;
        lane_we = 1'b1;
        addr    = clr.row;
        wbyte   = 8'h00;
      end else begin
        en      = req.en && (!req.we || req.word || lane == off);
        lane_we = req.we;
        addr    = rd_row;
        wbyte   = wsh[7:0];
      end
    end

    lms_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank (
      .clk   (clk),
      .en    (en),
      .we    (lane_we),
      .addr  (addr),
      .wdata (wbyte),
      .rdata (q[j])
    );

    assign rword[8*j +: 8] = q[LANE_W'(off_q + lane)];
  end

endmodule

// File: rtl/le_memory_stack_call_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// le_memory_stack_call_unit: byte memory with x86-style stack, call and ret
// Each request beat names one action; the response beat carries the loaded
// data and the updated stack and instruction pointers.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ---------------------------------------------
//  req      in   valid / ready  action, addr, data, rel, stack_ptr, instr_ptr
//  rsp      out  valid / ready  read_data, new_stack_ptr, new_instr_ptr
//
//  One request beat per cycle when not clearing and the output stage is free or leaving;
//  its response is valid the cycle after acceptance, with the bank read data.
//  Reset starts a clearing pass that zeroes the BANK_DEPTH (16384) rows of all
//  four banks, one row a cycle; req.ready stays low until it ends.
//  A stalled response holds the output stage; a new beat is taken in the
//  cycle the held response leaves.
//
module le_memory_stack_call_unit import lms_pkg::*; (
  input logic      clk,
  input logic      rst,
  lms_req_if.sink  req,
  lms_rsp_if.source rsp
);

  logic        accept;
  logic        clearing;
  logic [BANK_AW-1:0] clr_row;
  lms_req_t    mreq;
  lms_clr_t    mclr;
  logic [31:0] rword;

  logic        s_valid;
  logic [2:0]  s_act;
  logic [31:0] s_sp;
  logic [31:0] s_ip;

  logic [31:0] sp_dec;
  logic [31:0] sp_inc;
  logic [31:0] ip_ret;
  logic [31:0] sp_next;
  logic [31:0] ip_next;

  // Take a beat once clear is done and the output stage is free or leaving
  assign req.ready = !clearing && (!s_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == {BANK_AW{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  assign mclr.active = clearing;
  assign mclr.row    = clr_row;

  // Pointer arithmetic
  assign sp_dec = req.stack_ptr - SP_STEP;
  assign sp_inc = req.stack_ptr + SP_STEP;
  assign ip_ret = req.instr_ptr + CALL_LEN;

  // Build the memory access for the accepted beat
  always_comb begin
    mreq.en    = accept;
    mreq.we    = 1'b0;
    mreq.word  = 1'b1;
    mreq.addr  = req.addr[ADDR_W-1:0];
    mreq.wdata = req.data;
    sp_next    = req.stack_ptr;
    ip_next    = req.instr_ptr;
    case (req.action)
      ACT_RD8: begin
        mreq.word = 1'b0;
      end
      ACT_RD32: begin
      end
      ACT_WR8: begin
        mreq.we   = 1'b1;
        mreq.word = 1'b0;
      end
      ACT_WR32: begin
        mreq.we = 1'b1;
      end
      ACT_PUSH: begin
        mreq.we   = 1'b1;
        mreq.addr = sp_dec[ADDR_W-1:0];
        sp_next   = sp_dec;
      end
      ACT_POP: begin
        mreq.addr = req.stack_ptr[ADDR_W-1:0];
        sp_next   = sp_inc;
      end
      ACT_CALL: begin
        mreq.we    = 1'b1;
        mreq.addr  = sp_dec[ADDR_W-1:0];
        mreq.wdata = ip_ret;
        sp_next    = sp_dec;
        ip_next    = ip_ret + req.rel;
      end
      ACT_RET: begin
        mreq.addr = req.stack_ptr[ADDR_W-1:0];
        sp_next   = sp_inc;
      end
      default: begin
      end
    endcase
  end

  lms_banks u_banks (
    .clk   (clk),
    .req   (mreq),
    .clr   (mclr),
    .rword (rword)
  );

  // Output stage: advance on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (rsp.ready) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_act <= req.action;
      s_sp  <= sp_next;
      s_ip  <= ip_next;
    end
  end

  // Bank outputs hold between reads, so the response is stable while stalled
  always_comb begin
    rsp.read_data     = '0;
    rsp.new_instr_ptr = s_ip;
    case (s_act)
      ACT_RD8:  rsp.read_data = {24'h000000, rword[7:0]};
      ACT_RD32: rsp.read_data = rword;
      ACT_POP:  rsp.read_data = rword;
      ACT_RET:  rsp.new_instr_ptr = rword;
      default: begin
      end
    endcase
  end

  assign rsp.valid         = s_valid;
  assign rsp.new_stack_ptr = s_sp;

  // No beat enters while the banks are being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("request accepted during clearing pass");

  // Clearing ends only after the last row
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_row) == {BANK_AW{1'b1}})
    else $error("clearing pass ended early");

  // A response appears only after an accepted request
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(s_valid) |-> $past(accept))
    else $error("response without request");

  // A held response keeps its action
  a_hold_act: assert property (@(posedge clk) disable iff (rst)
    s_valid && !rsp.ready |=> $stable(s_act))
    else $error("stalled response changed action");

endmodule
